// ===== hdl/rdc_pkg.sv =====
// Shared types and constants for the ratio duty controller.
`timescale 1ns / 1ps
package rdc_pkg;

   localparam int TARGET_W     = 12;
   localparam int LIMIT_W      = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int TARGET_RESET = 400;
   localparam int LIMIT_RESET  = 20000;

   typedef enum logic [0:0] {
      CSR_TARGET_LEVEL = 1'b0,
      CSR_DUTY_LIMIT   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic div_step;
   } alu_ctrl_type;

endpackage

// ===== hdl/rdc_shared_alu.sv =====
// Shared adder datapath: serial shift-add multiply then restoring divide.
`timescale 1ns / 1ps
module rdc_shared_alu #(
   parameter int DUTY_BITS = 16,
   parameter int NUM_BITS  = 13
) (
   input  logic                               clock,
   input  rdc_pkg::alu_ctrl_type              ctrl,
   input  logic [DUTY_BITS-1:0]               a_in,
   input  logic [NUM_BITS-1:0]                num_in,
   input  logic [NUM_BITS-1:0]                den_in,
   output logic [DUTY_BITS+NUM_BITS:0]        quotient
);
   import rdc_pkg::*;

   localparam int PW = DUTY_BITS + NUM_BITS + 1;
   localparam int HW = DUTY_BITS + 1;
   localparam int AW = ((HW > NUM_BITS + 1) ? HW : NUM_BITS + 1) + 1;

   logic [PW-1:0]        p_ff, p_in;
   logic [NUM_BITS-1:0]  r_ff, r_in;
   logic [NUM_BITS-1:0]  den_ff;
   logic [DUTY_BITS-1:0] a_ff;
   logic [NUM_BITS:0]    rs;
   logic [AW-1:0]        op_a, op_b, sum;
   logic                 cin;

   assign rs = {r_ff, p_ff[PW-1]};

   always_comb begin
      op_a = '0;
      op_b = '0;
      cin  = 1'b0;
      if (ctrl.div_step) begin
         op_a = AW'(rs);
         op_b = ~AW'(den_ff);
         cin  = 1'b1;
      end else begin
         op_a = AW'(p_ff[PW-1:NUM_BITS]);
         op_b = p_ff[0] ? AW'(a_ff) : '0;
      end
   end

   assign sum = op_a + op_b + AW'(cin);

   always_comb begin
      p_in = p_ff;
      r_in = r_ff;
      if (ctrl.load) begin
         p_in = PW'(num_in);
         r_in = '0;
      end else if (ctrl.mul_step) begin
         p_in = {sum[HW-1:0], p_ff[NUM_BITS-1:0]} >> 1;
      end else if (ctrl.div_step) begin
         if (!sum[AW-1]) begin
            r_in = sum[NUM_BITS-1:0];
            p_in = {p_ff[PW-2:0], 1'b1};
         end else begin
            r_in = rs[NUM_BITS-1:0];
            p_in = {p_ff[PW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      r_ff <= r_in;
      if (ctrl.load) begin
         a_ff   <= a_in;
         den_ff <= den_in;
      end
   end

   assign quotient = p_ff;

endmodule

// ===== hdl/ratio_duty_controller_core.sv =====
// Ratio duty controller: per-sample duty update by exact rational scaling.
// Sequence: an accepted sample whose duty is scaled passes through the multiply state and the divide
// state before the output state; the zero-sample, hold and zero-duty cases go straight to output.
// One word is in progress at a time: req_ready is high only in idle, once the previous result is registered.
// The serial multiply runs SAMPLE_BITS+1 steps and the divide SAMPLE_BITS+DUTY_BITS+2 steps.
// Reset: synchronous; clears last sample and last duty, loads target 400 and limit 20000.
`timescale 1ns / 1ps
module ratio_duty_controller_core #(
   parameter int SAMPLE_BITS = 12,
   parameter int DUTY_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [SAMPLE_BITS-1:0]            req_measured_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [DUTY_BITS-1:0]              rsp_duty,
   input  logic                              csr_wr_en,
   input  rdc_pkg::csr_index_type            csr_index,
   input  logic [rdc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rdc_pkg::*;

   localparam int NW    = SAMPLE_BITS + 1;
   localparam int PW    = DUTY_BITS + NW + 1;
   localparam int DW    = SAMPLE_BITS + 2;
   localparam int CW    = $clog2(PW);
   localparam int TGT_W = (SAMPLE_BITS < TARGET_W) ? SAMPLE_BITS : TARGET_W;
   localparam int LIM_W = (DUTY_BITS < LIMIT_W) ? DUTY_BITS : LIMIT_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      KIND_HALF,
      KIND_KEEP,
      KIND_ZERO,
      KIND_SCALE
   } kind_type;

   state_type               state_ff;
   kind_type                kind_ff, kind_in;
   logic [CW-1:0]           cnt_ff;
   logic [TGT_W-1:0]        target_ff;
   logic [LIM_W-1:0]        limit_ff;
   logic [SAMPLE_BITS-1:0]  last_sample_ff;
   logic [DUTY_BITS-1:0]    last_duty_ff;
   logic                    rsp_valid_ff;
   logic [DUTY_BITS-1:0]    rsp_duty_ff;

   logic signed [DW-1:0]    d1, d2, dsum, nd1, ndsum, dgap;
   logic                    d1_pos, d1_neg, d2_pos, d2_neg;
   logic [NW-1:0]           num_in, den_in;
   logic                    accept;
   alu_ctrl_type            alu_ctrl;
   logic [PW-1:0]           quotient;
   logic [PW-1:0]           raw_duty;
   logic [DUTY_BITS-1:0]    duty_res;

   assign d1    = $signed({2'b00, req_measured_value}) - $signed({2'b00, last_sample_ff});
   assign d2    = $signed({{(DW-TGT_W){1'b0}}, target_ff})
                - $signed({2'b00, req_measured_value});
   assign dsum  = d1 + d2;
   assign nd1   = -d1;
   assign ndsum = -dsum;
   assign dgap  = d2 - d1;

   assign d1_neg = d1[DW-1];
   assign d2_neg = d2[DW-1];
   assign d1_pos = !d1_neg && (d1 != '0);
   assign d2_pos = !d2_neg && (d2 != '0);

   always_comb begin
      kind_in = KIND_KEEP;
      num_in  = '0;
      den_in  = '0;
      if (req_measured_value == '0) begin
         kind_in = KIND_HALF;
      end else if (d1_pos && d2_pos) begin
         kind_in = KIND_SCALE;
         num_in  = NW'(d2);
         den_in  = NW'(d1);
      end else if (d1_neg && d2_pos) begin
         kind_in = KIND_SCALE;
         num_in  = NW'(dgap);
         den_in  = NW'(nd1);
      end else if (d1_pos && d2_neg) begin
         if (dsum[DW-1] || (dsum == '0)) begin
            kind_in = KIND_ZERO;
         end else begin
            kind_in = KIND_SCALE;
            num_in  = NW'(d1);
            den_in  = NW'(dsum);
         end
      end else if (d1_neg && d2_neg) begin
         kind_in = KIND_SCALE;
         num_in  = NW'(nd1);
         den_in  = NW'(ndsum);
      end
   end

   assign accept            = (state_ff == ST_IDLE) && req_valid;
   assign alu_ctrl.load     = accept;
   assign alu_ctrl.mul_step = (state_ff == ST_MUL);
   assign alu_ctrl.div_step = (state_ff == ST_DIV);

   rdc_shared_alu #(
      .DUTY_BITS (DUTY_BITS),
      .NUM_BITS  (NW)
   ) u_rdc_shared_alu (
      .clock    (clock),
      .ctrl     (alu_ctrl),
      .a_in     (last_duty_ff),
      .num_in   (num_in),
      .den_in   (den_in),
      .quotient (quotient)
   );

   always_comb begin
      case (kind_ff)
         KIND_HALF:  raw_duty = PW'(limit_ff >> 1);
         KIND_KEEP:  raw_duty = PW'(last_duty_ff);
         KIND_SCALE: raw_duty = quotient;
         default:    raw_duty = '0;
      endcase
      if (raw_duty > PW'(limit_ff))
         duty_res = DUTY_BITS'(limit_ff);
      else
         duty_res = raw_duty[DUTY_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         last_sample_ff <= '0;
         last_duty_ff   <= '0;
         target_ff      <= TGT_W'(TARGET_RESET);
         limit_ff       <= LIM_W'(LIMIT_RESET);
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TARGET_LEVEL: target_ff <= csr_wdata[TGT_W-1:0];
               CSR_DUTY_LIMIT:   limit_ff  <= csr_wdata[LIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT))
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  last_sample_ff <= req_measured_value;
                  cnt_ff         <= '0;
                  state_ff       <= (kind_in == KIND_SCALE) ? ST_MUL : ST_OUT;
               end
            end
            ST_MUL: begin
               if (cnt_ff == CW'(NW - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DIV: begin
               if (cnt_ff == CW'(PW - 1))
                  state_ff <= ST_OUT;
               else
                  cnt_ff <= cnt_ff + 1'b1;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  last_duty_ff <= duty_res;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         kind_ff <= kind_in;
      if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready))
         rsp_duty_ff <= duty_res;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_duty  = rsp_duty_ff;

endmodule

// ===== hdl/rdc_checker.sv =====
// Port-level assertions for the ratio duty controller, bound to the top level.
`timescale 1ns / 1ps
module rdc_checker #(
   parameter int DUTY_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DUTY_BITS-1:0] rsp_duty
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty))
      else $error("result word changed while stalled");

   // one word in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous word in progress");

   // a new result only appears at the end of a busy period
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without work in progress");

endmodule

bind ratio_duty_controller_core rdc_checker #(
   .DUTY_BITS (DUTY_BITS)
) u_rdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_duty  (rsp_duty)
);
